// ----- src/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  // Operation kinds carried on the input tuser
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  // Result status codes carried on the output tuser
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 8;

  // Top value reported when the queue holds nothing
  localparam logic signed [ValueW-1:0] EmptyTop = '1;

  // Operation broadcast to every cell in the chain
  typedef struct packed {
    logic                     push;
    logic                     pop;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- src/sorted_priority_queue_core.sv -----
// Top level: max-priority queue built as a chain of sorted cells.
// Each result is registered and presented in the cycle after its item is accepted.
// Throughput: one push or pop per cycle while the result side takes every result.
// One output register: a waiting result holds off input until it is taken.
// Reset (async, active low) empties the queue and drops any pending result;
// cell contents are not reset and are only read below the entry count.
module sorted_priority_queue_core #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] value
  input  logic        s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [31:0] removed_value, [63:32] top_value,
                                        // [71:64] entry_count
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned VW   = spq_pkg::ValueW;

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q;
  logic [71:0]     out_data_q;
  logic [1:0]      out_user_q;

  logic            accept, is_pop, full, empty;
  spq_pkg::status_e    status;
  spq_pkg::cell_ctrl_t ctrl;
  logic signed [VW-1:0] removed, top_next;

  logic                 keep    [QUEUE_DEPTH];
  logic signed [VW-1:0] cell_val[QUEUE_DEPTH];
  logic signed [VW-1:0] cell_d  [QUEUE_DEPTH];

  // Input handshake: taken whenever the output register is free or draining
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign is_pop = (s_axis_tuser_i == spq_pkg::OP_POP);
  assign full   = (count_q == CntW'(QUEUE_DEPTH));
  assign empty  = (count_q == '0);

  // Operation broadcast to the chain
  always_comb begin
    ctrl.push  = accept && !is_pop && !full;
    ctrl.pop   = accept && is_pop && !empty;
    ctrl.value = $signed(s_axis_tdata_i);
  end

  // Cell chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                 left_keep;
    logic signed [VW-1:0] left_val, right_val;
    if (i == 0) begin : g_head
      assign left_keep = 1'b1;
      assign left_val  = cell_val[i];
    end else begin : g_body
      assign left_keep = keep[i-1];
      assign left_val  = cell_val[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_val = cell_val[i];
    end else begin : g_inner
      assign right_val = cell_val[i+1];
    end
    spq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .valid_i    (CntW'(i) < count_q),
      .left_keep_i(left_keep),
      .left_val_i (left_val),
      .right_val_i(right_val),
      .keep_o     (keep[i]),
      .val_o      (cell_val[i]),
      .val_d_o    (cell_d[i])
    );
  end

  // Count update and result fields
  always_comb begin
    count_d = count_q;
    status  = spq_pkg::ST_DONE;
    removed = '0;
    if (accept) begin
      if (!is_pop) begin
        if (full) begin
          status = spq_pkg::ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
        end
      end else begin
        if (empty) begin
          status = spq_pkg::ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
          removed = cell_val[0];
        end
      end
    end
    top_next = (count_d == '0) ? spq_pkg::EmptyTop : cell_d[0];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {spq_pkg::CountW'(count_d), top_next, removed};
      out_user_q <= status;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef SYNTHESIS
  // Count never passes the depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  // Pop on empty leaves count and flags the result
  a_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_pop && empty) |=>
      (count_q == '0 && m_axis_tvalid_o && m_axis_tuser_o == spq_pkg::ST_EMPTY))
    else $error("pop on empty misreported");

  // Accepted push below depth grows the count by one
  a_push_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_pop && !full) |=> (count_q == $past(count_q) + 1'b1))
    else $error("push did not add an entry");

  // Every accepted item yields a pending result
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_axis_tvalid_o)
    else $error("result missing after accepted item");
`endif

endmodule

// ----- src/spq_cell.sv -----
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell (
  input  logic                               clk_i,
  input  spq_pkg::cell_ctrl_t                ctrl_i,
  input  logic                               valid_i,
  input  logic                               left_keep_i,
  input  logic signed [spq_pkg::ValueW-1:0]  left_val_i,
  input  logic signed [spq_pkg::ValueW-1:0]  right_val_i,
  output logic                               keep_o,
  output logic signed [spq_pkg::ValueW-1:0]  val_o,
  output logic signed [spq_pkg::ValueW-1:0]  val_d_o
);

  logic signed [spq_pkg::ValueW-1:0] val_q, val_d;

  // Entry stays put on a push if it is held and not below the new value
  assign keep_o = valid_i && (val_q >= ctrl_i.value);

  // Next entry: shift up on pop, insert or shift down on push
  always_comb begin
    val_d = val_q;
    if (ctrl_i.pop) begin
      val_d = right_val_i;
    end else if (ctrl_i.push && !keep_o) begin
      if (left_keep_i) begin
        val_d = ctrl_i.value;
      end else begin
        val_d = left_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign val_d_o = val_d;

endmodule

// ----- sim/spq_checker.sv -----
// Checker for the sorted priority queue: predicts each result and compares it.
`timescale 1ns / 100ps

module spq_checker #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [31:0] in_data_i,   // [31:0] value
  input  logic        in_user_i,   // [0] func
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [71:0] out_data_i,  // [31:0] removed_value, [63:32] top_value,
                                   // [71:64] entry_count
  input  logic [1:0]  out_user_i,  // [1:0] status
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    spq_pkg::status_e           status;
    logic [spq_pkg::ValueW-1:0] removed;
    logic [spq_pkg::ValueW-1:0] top;
    logic [spq_pkg::CountW-1:0] count;
  } outcome_t;

  // Shadow copy of the store, largest value first
  logic signed [spq_pkg::ValueW-1:0] held_entries[$];
  // Outcomes of accepted items whose results have not been taken yet
  outcome_t                          awaited_outcomes[$];
  outcome_t                          want;

  // Apply one push or pop to the shadow store and return the outcome
  function automatic outcome_t apply_queue_op(spq_pkg::op_e op,
                                              logic signed [spq_pkg::ValueW-1:0] value);
    outcome_t res;
    int       slot;
    res.status  = spq_pkg::ST_DONE;
    res.removed = '0;
    if (op == spq_pkg::OP_PUSH) begin
      if (held_entries.size() >= QUEUE_DEPTH) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        // new value goes behind every entry greater than or equal to it
        slot = 0;
        while (slot < held_entries.size() && held_entries[slot] >= value) slot++;
        held_entries.insert(slot, value);
      end
    end else if (held_entries.size() == 0) begin
      res.status = spq_pkg::ST_EMPTY;
    end else begin
      res.removed = held_entries.pop_front();
    end
    res.top   = (held_entries.size() == 0) ? spq_pkg::EmptyTop : held_entries[0];
    res.count = spq_pkg::CountW'(held_entries.size());
    return res;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  // Inputs are taken before results so an item and a result on one edge stay in order
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_entries.delete();
      awaited_outcomes.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        awaited_outcomes.push_back(apply_queue_op(spq_pkg::op_e'(in_user_i), in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result taken with no item outstanding");
          fail_count_o++;
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("status", 32'(want.status), 32'(out_user_i));
          check_field("removed_value", want.removed, out_data_i[31:0]);
          check_field("top_value", want.top, out_data_i[63:32]);
          check_field("entry_count", 32'(want.count), 32'(out_data_i[71:64]));
        end
      end
      pending_o = awaited_outcomes.size();
    end
  end

endmodule

// ----- sim/sorted_priority_queue_core_tb.sv -----
// Testbench top for the sorted priority queue: stimulus, stalls and verdict.
`timescale 1ns / 100ps

module sorted_priority_queue_core_tb;

  localparam int unsigned QueueDepth = 128;
  localparam int          CycleLimit = 500000;
  localparam int          PhaseItems = 166;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [31:0] s_data;
  logic        s_op;
  logic        m_valid;
  logic        m_ready;
  logic [71:0] m_data;
  logic [1:0]  m_status;
  int          fail_count;
  int          pending;
  int          cycle_count = 0;

  always #10 clk = ~clk;

  sorted_priority_queue_core #(
    .QUEUE_DEPTH(QueueDepth)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_op),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_status)
  );

  spq_checker #(
    .QUEUE_DEPTH(QueueDepth)
  ) queue_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (s_valid),
    .in_ready_i  (s_ready),
    .in_data_i   (s_data),
    .in_user_i   (s_op),
    .out_valid_i (m_valid),
    .out_ready_i (m_ready),
    .out_data_i  (m_data),
    .out_user_i  (m_status),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Values: extremes, a narrow band that yields many ties, or anything
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2, 3: return 32'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Idle cycles between items: mostly none or short, a few long
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one item, hold it until accepted, then idle for a picked gap, which may be none
  task automatic issue_item(spq_pkg::op_e op, logic [31:0] value, bit quiet);
    int gap;
    s_valid <= 1'b1;
    s_op    <= op;
    s_data  <= value;
    do @(posedge clk); while (!s_ready);
    gap = pick_gap(quiet);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side back-pressure: ready bursts broken by short or long stalls
  initial begin
    int high_len;
    int low_len;
    m_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      low_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
      m_ready <= 1'b1;
      repeat (high_len) @(posedge clk);
      if (low_len > 0) begin
        m_ready <= 1'b0;
        repeat (low_len) @(posedge clk);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int           push_pct;
    bit           quiet;
    spq_pkg::op_e op;
    s_valid = 1'b0;
    s_op    = spq_pkg::OP_PUSH;
    s_data  = '0;
    rst_n   = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pops, extreme values, ties, drain to empty and past it
    issue_item(spq_pkg::OP_POP, 32'hDEAD_BEEF, 1'b0);
    issue_item(spq_pkg::OP_POP, 32'hFFFF_FFFF, 1'b0);
    issue_item(spq_pkg::OP_PUSH, 32'h0000_0000, 1'b0);
    issue_item(spq_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b0);
    issue_item(spq_pkg::OP_PUSH, 32'h8000_0000, 1'b0);
    issue_item(spq_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b0);
    issue_item(spq_pkg::OP_PUSH, 32'h0000_0001, 1'b0);
    issue_item(spq_pkg::OP_PUSH, 32'h0000_0005, 1'b0);
    issue_item(spq_pkg::OP_PUSH, 32'h0000_0005, 1'b0);
    issue_item(spq_pkg::OP_PUSH, 32'hFFFF_FFFF, 1'b0);
    issue_item(spq_pkg::OP_POP, 32'hFFFF_FFFF, 1'b0);
    issue_item(spq_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b1);
    repeat (9) issue_item(spq_pkg::OP_POP, 32'h0000_0000, 1'b1);
    issue_item(spq_pkg::OP_POP, 32'h0000_0000, 1'b0);

    // Random phases: fill past full, drain past empty, mixed, fill, drain
    quiet = 1'b0;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       push_pct = 92;
        1:       push_pct = 8;
        2:       push_pct = 50;
        3:       push_pct = 95;
        default: push_pct = 5;
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        op = ($urandom_range(1, 100) <= push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP;
        issue_item(op, pick_value(), quiet);
      end
    end
    s_valid <= 1'b0;

    // Drain outstanding results, then wait for any stray output
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_core.sv
sim/spq_checker.sv
sim/sorted_priority_queue_core_tb.sv
